[sv/plu_pkg.sv]
// plu_pkg: shared types, codes and defaults for the positional list unit.
// Used by plu_ctrl, plu_dp and positional_list_insert_remove_unit.
`default_nettype none

package plu_pkg;

  localparam int DEPTH_DEF = 16;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [4:0]         position;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [4:0]         entry_count;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SH_RD,
    S_SH_WR,
    S_INS_WR,
    S_RD_CAP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic shift_rd;
    logic shift_wr;
    logic ins_wr;
    logic rd_cap;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic op_ok;
    logic is_insert;
    logic is_remove;
    logic is_read;
    logic need_shift;
    logic shift_last;
    logic out_free;
  } ctl_sts_t;

endpackage

`default_nettype wire

[sv/plu_ram.sv]
// plu_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module plu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/plu_ctrl.sv]
// plu_ctrl: request sequencer for the positional list unit.
// Depends on plu_pkg; drives plu_dp through ctl_cmd_t, observes ctl_sts_t.
`default_nettype none

module plu_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire plu_pkg::ctl_sts_t  sts,
  output plu_pkg::ctl_cmd_t       cmd
);

  plu_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= plu_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      plu_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = plu_pkg::S_DECODE;
        end
      end
      plu_pkg::S_DECODE: begin
        cmd.decode = 1'b1;
        if (!sts.op_ok) begin
          state_nxt = plu_pkg::S_DONE;
        end else if (sts.is_insert) begin
          state_nxt = sts.need_shift ? plu_pkg::S_SH_RD : plu_pkg::S_INS_WR;
        end else if (sts.is_remove) begin
          state_nxt = sts.need_shift ? plu_pkg::S_SH_RD : plu_pkg::S_DONE;
        end else if (sts.is_read) begin
          state_nxt = plu_pkg::S_RD_CAP;
        end else begin
          state_nxt = plu_pkg::S_DONE;
        end
      end
      plu_pkg::S_SH_RD: begin
        cmd.shift_rd = 1'b1;
        state_nxt    = plu_pkg::S_SH_WR;
      end
      plu_pkg::S_SH_WR: begin
        cmd.shift_wr = 1'b1;
        if (!sts.shift_last) begin
          state_nxt = plu_pkg::S_SH_RD;
        end else if (sts.is_insert) begin
          state_nxt = plu_pkg::S_INS_WR;
        end else begin
          state_nxt = plu_pkg::S_DONE;
        end
      end
      plu_pkg::S_INS_WR: begin
        cmd.ins_wr = 1'b1;
        state_nxt  = plu_pkg::S_DONE;
      end
      plu_pkg::S_RD_CAP: begin
        cmd.rd_cap = 1'b1;
        state_nxt  = plu_pkg::S_DONE;
      end
      plu_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = plu_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = plu_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/plu_dp.sv]
// plu_dp: datapath of the positional list unit: request registers, entry count,
// shift pointer, entry RAM (plu_ram) and output register. Depends on plu_pkg.
`default_nettype none

module plu_dp #(
  parameter int DEPTH = plu_pkg::DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire plu_pkg::in_word_t  in_word,
  input  wire plu_pkg::ctl_cmd_t  cmd,
  output plu_pkg::ctl_sts_t       sts,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output plu_pkg::out_word_t      out_word
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = ((CW > 5) ? CW : 5) + 1;

  logic [1:0]         act_r;
  logic [4:0]         pos_r;
  logic signed [31:0] val_r;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]      ptr_r;
  logic [1:0]         status_r, status_c;
  logic signed [31:0] rd_r;
  logic               out_valid_r;
  plu_pkg::out_word_t out_word_r;

  logic [MW-1:0] pos_x, cnt_x, ptr_x, depth_x, cnt_nxt_x;
  logic [AW-1:0] src;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  assign pos_x   = MW'(pos_r);
  assign cnt_x   = MW'(cnt_r);
  assign ptr_x   = MW'(ptr_r);
  assign depth_x = MW'(DEPTH);

  assign sts.is_insert = (act_r == plu_pkg::ACT_INSERT);
  assign sts.is_remove = (act_r == plu_pkg::ACT_REMOVE);
  assign sts.is_read   = (act_r == plu_pkg::ACT_READ);

  always_comb begin
    case (act_r)
      plu_pkg::ACT_INSERT: begin
        if (pos_x > cnt_x) begin
          status_c = plu_pkg::ST_RANGE;
        end else if (cnt_x == depth_x) begin
          status_c = plu_pkg::ST_FULL;
        end else begin
          status_c = plu_pkg::ST_OK;
        end
      end
      plu_pkg::ACT_REMOVE, plu_pkg::ACT_READ: begin
        status_c = (pos_x < cnt_x) ? plu_pkg::ST_OK : plu_pkg::ST_RANGE;
      end
      default: begin
        status_c = plu_pkg::ST_RANGE;
      end
    endcase
  end

  assign sts.op_ok      = (status_c == plu_pkg::ST_OK);
  assign sts.need_shift = sts.is_insert ? (cnt_x > pos_x) :
                          sts.is_remove ? ((pos_x + MW'(1)) < cnt_x) : 1'b0;
  assign sts.shift_last = sts.is_insert ? (ptr_x == (pos_x + MW'(1))) :
                          ((ptr_x + MW'(2)) == cnt_x);
  assign sts.out_free   = !out_valid_r || !out_stall;

  // insert moves entries up (source below), remove moves them down
  assign src   = sts.is_insert ? (ptr_r - AW'(1)) : (ptr_r + AW'(1));
  assign raddr = cmd.shift_rd ? src : pos_x[AW-1:0];
  assign we    = cmd.shift_wr || cmd.ins_wr;
  assign waddr = cmd.ins_wr ? pos_x[AW-1:0] : ptr_r;
  assign wdata = cmd.ins_wr ? val_r : rdata;

  plu_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.finish && (status_r == plu_pkg::ST_OK)) begin
      if (sts.is_insert) begin
        cnt_nxt = cnt_r + CW'(1);
      end else if (sts.is_remove) begin
        cnt_nxt = cnt_r - CW'(1);
      end
    end
  end

  assign cnt_nxt_x = MW'(cnt_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_word.action;
      pos_r <= in_word.position;
      val_r <= in_word.value;
    end
    if (cmd.decode) begin
      status_r <= status_c;
      rd_r     <= '0;
      ptr_r    <= sts.is_insert ? cnt_x[AW-1:0] : pos_x[AW-1:0];
    end
    if (cmd.shift_wr) begin
      ptr_r <= src;
    end
    if (cmd.rd_cap) begin
      rd_r <= rdata;
    end
    if (cmd.finish) begin
      out_word_r.status      <= status_r;
      out_word_r.read_value  <= rd_r;
      out_word_r.entry_count <= cnt_nxt_x[4:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_x <= depth_x)
    else $error("entry count above depth");

  a_wr_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (MW'(waddr) <= cnt_x))
    else $error("entry write beyond list end");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> sts.out_free)
    else $error("result overwrote a pending word");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && (status_r == plu_pkg::ST_OK) && sts.is_insert
    |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("insert did not grow the list");

endmodule

`default_nettype wire

[sv/positional_list_insert_remove_unit.sv]
// positional_list_insert_remove_unit: bounded ordered list of signed 32-bit
// entries with insert, remove and read by position. Depends on plu_pkg,
// plu_ctrl, plu_dp and plu_ram.
//
// Input channel in_valid/in_stall/in_word carries one request word (action,
// position, value). Output channel out_valid/out_stall/out_word returns one
// result word per request (status, read_value, entry_count after the request).
// A word moves on a clock edge where valid is high and stall is low.
//
// Requests are handled one at a time. An accepted request is decoded; an
// error or a remove of the last entry goes straight to the result, a read
// captures its entry, and others move entries as needed, an insert then
// writing its value. The entries live in a single-port-write RAM, so each
// moved entry takes a read step and a write step. The next request is taken
// the cycle after the result is registered, even while it waits on out_stall;
// the unit holds only when a second result is ready and the first is stalled.
//
// Reset (rst_n low, synchronous) empties the list and drops out_valid; entry
// storage is not cleared since only written positions are ever read.
`default_nettype none

module positional_list_insert_remove_unit #(
  parameter int DEPTH = plu_pkg::DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire plu_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output plu_pkg::out_word_t      out_word
);

  plu_pkg::ctl_cmd_t cmd;
  plu_pkg::ctl_sts_t sts;

  plu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  plu_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire
